// ===== rtl/lcbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbb_pkg
// shared constants, beat layouts and controller/datapath signal groups
// ----------------------------------------------------------------------------
package lcbb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;
    localparam int BAND_ROWS_DEF     = 4;
    localparam int HEAP_DEPTH_DEF    = 1024;

    localparam int COORD_W   = 12;            // input coordinate and size width
    localparam int POS_W     = COORD_W - 1;   // clipped, non-negative coordinate
    localparam int EXT_W     = COORD_W + 2;   // signed room for pos + size
    localparam int ADDR_W    = 32;
    localparam int SLOT_W    = 10;
    localparam int HEAD_W    = 11;
    localparam int FREE_W    = 11;
    localparam int MIX_W     = 8;
    localparam int ROWS_W    = 5;             // rows of one band, up to 31
    localparam int DIV_SHIFT = 16;            // reciprocal scale for row / band rows

    localparam logic [HEAD_W-1:0] EMPTY_HEAD = HEAD_W'(1024);

    // input beat, highest field first
    typedef struct packed {
        logic [MIX_W-1:0]   mix_level;
        logic [MIX_W-1:0]   mix_type;
        logic [ADDR_W-1:0]  source_base;
        logic [COORD_W-1:0] size_y;
        logic [COORD_W-1:0] size_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } in_beat_t;

    // output beat, highest field first, padded to whole bytes
    typedef struct packed {
        logic [5:0]         pad;
        logic [MIX_W-1:0]   mix_level_out;
        logic [MIX_W-1:0]   mix_type_out;
        logic [2:0]         rows;
        logic [8:0]         width;
        logic [13:0]        source_stride;
        logic [12:0]        dest_offset;
        logic [ADDR_W-1:0]  source_addr;
        logic [5:0]         band;
        logic [HEAD_W-1:0]  next_slot;
        logic [SLOT_W-1:0]  slot;
    } out_beat_t;

    localparam int IN_DATA_W  = $bits(in_beat_t);
    localparam int OUT_DATA_W = $bits(out_beat_t);

    typedef struct packed {
        logic load;
        logic clear;
        logic clip;
        logic mula;
        logic mulb;
        logic divfix;
        logic step;
    } lcbb_cmd_t;

    typedef struct packed {
        logic empty;
        logic out_free;
        logic band_last;
        logic heap_full;
    } lcbb_stat_t;

endpackage

// ===== rtl/lcbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcbb_ctrl
// sequencer: accepts one item, steps the datapath through clip, setup
// multiplies and band division, then, unless the output stalls, one band per cycle
// ----------------------------------------------------------------------------
module lcbb_ctrl
    import lcbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_kind,
    output logic       in_ready,
    output lcbb_cmd_t  cmd,
    input  lcbb_stat_t stat
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLIP   = 7'b0000010,
        ST_MULA   = 7'b0000100,
        ST_MULB   = 7'b0001000,
        ST_DIVFIX = 7'b0010000,
        ST_PRIME  = 7'b0100000,
        ST_RUN    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_CLIP;
                    end
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = stat.empty ? ST_IDLE : ST_MULA;
            end
            ST_MULA:
            begin
                cmd.mula   = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                cmd.mulb   = 1'b1;
                state_next = ST_DIVFIX;
            end
            ST_DIVFIX:
            begin
                cmd.divfix = 1'b1;
                state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                // head memory read of the first band is issued here
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.heap_full || stat.band_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lcbb_datapath.sv =====
// ----------------------------------------------------------------------------
// lcbb_datapath
// clip arithmetic, source address setup, band head memory, slot counter
// and the output beat register
// ----------------------------------------------------------------------------
module lcbb_datapath
    import lcbb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int BAND_ROWS     = BAND_ROWS_DEF,
    parameter int HEAP_DEPTH    = HEAP_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  lcbb_cmd_t  cmd,
    output lcbb_stat_t stat,
    input  in_beat_t   in_data,
    input  logic       out_ready,
    output logic       out_valid,
    output out_beat_t  out_data,
    output logic       out_user,
    output logic       out_last
);

    localparam int NUM_BANDS = (SCREEN_HEIGHT + BAND_ROWS - 1) / BAND_ROWS;
    localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int QP_W      = POS_W + RECIP_W;

    localparam logic [RECIP_W-1:0]      RECIP_C = RECIP_W'((1 << DIV_SHIFT) / BAND_ROWS);
    localparam logic signed [EXT_W-1:0] SW_E    = EXT_W'(SCREEN_WIDTH);
    localparam logic signed [EXT_W-1:0] SH_E    = EXT_W'(SCREEN_HEIGHT);
    localparam logic [COORD_W-1:0]      BR_C    = COORD_W'(BAND_ROWS);
    localparam logic [FREE_W-1:0]       HEAP_C  = FREE_W'(HEAP_DEPTH);
    localparam logic [ADDR_W-1:0]       ROW_C   = ADDR_W'(4 * SCREEN_WIDTH);

    in_beat_t             in_reg;
    logic [POS_W-1:0]     x1_reg;
    logic [POS_W-1:0]     y1_reg;
    logic [COORD_W-1:0]   y2_reg;
    logic [COORD_W-1:0]   w_reg;
    logic [COORD_W-1:0]   dx_reg;
    logic [COORD_W-1:0]   dy_reg;
    logic [2*COORD_W-1:0] prod_reg;
    logic [POS_W-1:0]     qe_reg;
    logic [ADDR_W-1:0]    src_reg;
    logic [13:0]          stride_reg;
    logic [12:0]          dest_reg;
    logic [BAND_W-1:0]    b_reg;
    logic [COORD_W-1:0]   top_reg;
    logic                 first_reg;
    logic [FREE_W-1:0]    next_free_reg;
    logic [NUM_BANDS-1:0] head_valid_reg;
    logic [SLOT_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;
    logic                 out_valid_reg;
    out_beat_t            out_beat_reg;
    logic                 out_user_reg;
    logic                 out_last_reg;

    logic [SLOT_W-1:0]    band_mem [NUM_BANDS];

    // clip
    logic signed [EXT_W-1:0] px_e, py_e, sx_e, sy_e;
    logic signed [EXT_W-1:0] x1_e, y1_e, x2s, y2s, x2_e, y2_e, w_e, h_e, dx_e, dy_e;
    logic                    empty;

    // setup
    logic [QP_W-1:0]    qprod;
    logic [COORD_W-1:0] qb;
    logic [COORD_W-1:0] rem_raw;
    logic               rem_fix;
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] b_sum;
    logic [ADDR_W-1:0]  dest_sum;
    logic [13:0]        sdiff;

    // band step
    logic [COORD_W:0]      bot;
    logic [COORD_W-1:0]    r0, r1;
    logic [ROWS_W-1:0]     rows;
    logic                  band_last;
    logic                  heap_full;
    logic [HEAD_W-1:0]     head;
    logic [11:0]           b_ext;
    logic [18:0]           adv;
    logic                  mem_we;
    logic                  advance;
    logic [BAND_W-1:0]     rd_addr;
    out_beat_t             beat;

    always_comb
    begin
        px_e  = {{2{in_reg.pos_x[COORD_W-1]}}, in_reg.pos_x};
        py_e  = {{2{in_reg.pos_y[COORD_W-1]}}, in_reg.pos_y};
        sx_e  = {2'b00, in_reg.size_x};
        sy_e  = {2'b00, in_reg.size_y};
        x1_e  = px_e[EXT_W-1] ? '0 : px_e;
        y1_e  = py_e[EXT_W-1] ? '0 : py_e;
        x2s   = px_e + sx_e;
        y2s   = py_e + sy_e;
        x2_e  = (x2s > SW_E) ? SW_E : x2s;
        y2_e  = (y2s > SH_E) ? SH_E : y2s;
        w_e   = x2_e - x1_e;
        h_e   = y2_e - y1_e;
        dx_e  = x1_e - px_e;
        dy_e  = y1_e - py_e;
        empty = w_e[EXT_W-1] || (w_e == '0) || h_e[EXT_W-1] || (h_e == '0);
    end

    always_comb
    begin
        // row / band rows by reciprocal, low estimate corrected by one
        qprod    = y1_reg * RECIP_C;
        qb       = COORD_W'(qe_reg * BR_C);
        rem_raw  = {1'b0, y1_reg} - qb;
        rem_fix  = (rem_raw >= BR_C);
        rem      = rem_fix ? (rem_raw - BR_C) : rem_raw;
        b_sum    = {1'b0, qe_reg} + COORD_W'(rem_fix);
        dest_sum = ADDR_W'({x1_reg, 2'b00}) + ADDR_W'(rem) * ROW_C;
        sdiff    = {2'b00, in_reg.size_x} - {2'b00, w_reg};
    end

    always_comb
    begin
        bot       = {1'b0, top_reg} + {1'b0, BR_C};
        r0        = first_reg ? {1'b0, y1_reg} : top_reg;
        r1        = ({1'b0, y2_reg} < bot) ? y2_reg : bot[COORD_W-1:0];
        rows      = ROWS_W'(r1 - r0);
        band_last = (bot >= {1'b0, y2_reg});
        heap_full = (next_free_reg >= HEAP_C);
        head      = rd_valid_reg ? {{(HEAD_W-SLOT_W){1'b0}}, rd_data_reg} : EMPTY_HEAD;
        b_ext     = 12'(b_reg);
        adv       = {in_reg.size_x, 2'b00} * rows;
        mem_we    = cmd.step && !heap_full;
        advance   = mem_we && !band_last;
        rd_addr   = advance ? (b_reg + 1'b1) : b_reg;

        beat      = '0;
        beat.band = b_ext[5:0];
        if (!heap_full)
        begin
            beat.slot          = next_free_reg[SLOT_W-1:0];
            beat.next_slot     = head;
            beat.source_addr   = src_reg;
            beat.dest_offset   = dest_reg;
            beat.source_stride = stride_reg;
            beat.width         = w_reg[8:0];
            beat.rows          = rows[2:0];
            beat.mix_type_out  = in_reg.mix_type;
            beat.mix_level_out = in_reg.mix_level;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.clip)
        begin
            x1_reg <= x1_e[POS_W-1:0];
            y1_reg <= y1_e[POS_W-1:0];
            y2_reg <= y2_e[COORD_W-1:0];
            w_reg  <= w_e[COORD_W-1:0];
            dx_reg <= dx_e[COORD_W-1:0];
            dy_reg <= dy_e[COORD_W-1:0];
        end
        if (cmd.mula)
        begin
            prod_reg <= in_reg.size_x * dy_reg;
        end
        if (cmd.mulb)
        begin
            src_reg <= in_reg.source_base + ADDR_W'({dx_reg, 2'b00})
                     + ADDR_W'({prod_reg, 2'b00});
            qe_reg  <= qprod[DIV_SHIFT +: POS_W];
        end
        if (cmd.divfix)
        begin
            b_reg      <= b_sum[BAND_W-1:0];
            top_reg    <= {1'b0, y1_reg} - rem;
            dest_reg   <= dest_sum[12:0];
            stride_reg <= {sdiff[11:0], 2'b00};
            first_reg  <= 1'b1;
        end
        else if (advance)
        begin
            b_reg     <= b_reg + 1'b1;
            top_reg   <= bot[COORD_W-1:0];
            dest_reg  <= {x1_reg, 2'b00};
            src_reg   <= src_reg + ADDR_W'(adv);
            first_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            out_beat_reg <= beat;
            out_user_reg <= heap_full;
            out_last_reg <= heap_full || band_last;
        end
    end

    // band list heads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            band_mem[b_reg] <= next_free_reg[SLOT_W-1:0];
        end
        rd_data_reg <= band_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= '0;
            head_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= head_valid_reg[rd_addr];
            if (cmd.clear)
            begin
                next_free_reg  <= '0;
                head_valid_reg <= '0;
            end
            else if (mem_we)
            begin
                next_free_reg          <= next_free_reg + 1'b1;
                head_valid_reg[b_reg]  <= 1'b1;
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.empty     = empty;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.band_last = band_last;
    assign stat.heap_full = heap_full;

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/layer_clip_and_band_binning_top.sv =====
// ----------------------------------------------------------------------------
// layer_clip_and_band_binning_top
// clips layer rectangles to the screen and bins them into row bands
//
// s_axis: one beat per layer rectangle (tuser low) or frame reset (tuser high).
// m_axis: one descriptor beat per band the clipped layer covers, top to
// bottom; tlast marks the final beat of a layer. tuser high flags a slot
// overflow beat, which ends the layer's run.
// an add beat steps through clip, two setup multiplies, band division and
// the head memory read, then gives one band per cycle from the head memory.
// a fully clipped layer gives no beat and ends after the clip step.
// the first descriptor beat is registered after the head memory read.
// a stalled m_axis holds the band loop; one finished beat waits in the
// output register. reset empties all band lists and the slot counter.
// ----------------------------------------------------------------------------
module layer_clip_and_band_binning_top
    import lcbb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int BAND_ROWS     = BAND_ROWS_DEF,
    parameter int HEAP_DEPTH    = HEAP_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, size_x, size_y, source_base, mix_type, mix_level
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot, next_slot, band, source_addr, dest_offset, source_stride, width,
    // rows, mix_type_out, mix_level_out, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // overflow
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    lcbb_cmd_t  cmd;
    lcbb_stat_t stat;
    out_beat_t  out_beat;

    lcbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcbb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BAND_ROWS     (BAND_ROWS),
        .HEAP_DEPTH    (HEAP_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_beat_t'(s_axis_tdata)),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_beat),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_beat;

endmodule
